// File: rtl/cbnp_pkg.sv
// shared constants, types and codes for the custom base number parser
package cbnp_pkg;

  localparam int MAX_DIGITS_DEF  = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int CHAR_W          = 8;
  localparam int CFG_W           = 64;
  localparam int LEN_W           = 5;
  localparam int CFG_ADDR_W      = 2;
  localparam int STATUS_W        = 2;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_DIGITS_LO = 2'd0,
    CFG_DIGITS_HI = 2'd1,
    CFG_BASE_LEN  = 2'd2
  } cfg_addr_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_BASE = 2'd1,
    STATUS_BAD_CHAR = 2'd2
  } status_e;

  typedef struct packed {
    logic [2*CFG_W-1:0] digits;
    logic [LEN_W-1:0]   base_len;
    logic               base_ok;
  } cfg_t;

  typedef struct packed {
    logic hit;
    logic is_plus;
    logic is_minus;
    logic is_space;
    logic is_alnum;
  } char_class_t;

endpackage

// File: rtl/cbnp_cfg.sv
// configuration registers and registered alphabet validity check
module cbnp_cfg import cbnp_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  output cfg_t                  cfg_o
);

  logic [2*CFG_W-1:0] digits_q, digits_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic               base_ok_q, base_ok_d;

  always_comb begin
    digits_d = digits_q;
    len_d    = len_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_DIGITS_LO: digits_d[CFG_W-1:0]       = cfg_wdata_i;
        CFG_DIGITS_HI: digits_d[2*CFG_W-1:CFG_W] = cfg_wdata_i;
        CFG_BASE_LEN:  len_d                     = cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // checked on the next values so the flag always matches the registers
  always_comb begin
    logic [CHAR_W-1:0] c;
    base_ok_d = (len_d >= LEN_W'(2)) && (len_d <= LEN_W'(MAX_DIGITS));
    for (int i = 0; i < MAX_DIGITS; i++) begin
      c = digits_d[i*CHAR_W +: CHAR_W];
      if (LEN_W'(i) < len_d) begin
        if (c == CH_PLUS || c == CH_MINUS) begin
          base_ok_d = 1'b0;
        end
        for (int j = i + 1; j < MAX_DIGITS; j++) begin
          if (LEN_W'(j) < len_d && digits_d[j*CHAR_W +: CHAR_W] == c) begin
            base_ok_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q  <= '0;
      len_q     <= '0;
      base_ok_q <= 1'b0;
    end else begin
      digits_q  <= digits_d;
      len_q     <= len_d;
      base_ok_q <= base_ok_d;
    end
  end

  assign cfg_o.digits   = digits_q;
  assign cfg_o.base_len = len_q;
  assign cfg_o.base_ok  = base_ok_q;

endmodule

// File: rtl/cbnp_lookup.sv
// character classification and digit position lookup against the alphabet
module cbnp_lookup import cbnp_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int IDX_W      = $clog2(MAX_DIGITS)
) (
  input  logic [CHAR_W-1:0] char_i,
  input  cfg_t              cfg_i,
  output char_class_t       cls_o,
  output logic [IDX_W-1:0]  pos_o
);

  logic             hit;
  logic [IDX_W-1:0] pos;

  // walk downwards so the lowest matching position wins
  always_comb begin
    hit = 1'b0;
    pos = '0;
    for (int k = MAX_DIGITS - 1; k >= 0; k--) begin
      if (LEN_W'(k) < cfg_i.base_len && cfg_i.digits[k*CHAR_W +: CHAR_W] == char_i) begin
        hit = 1'b1;
        pos = IDX_W'(k);
      end
    end
  end

  assign cls_o.hit      = hit;
  assign cls_o.is_plus  = (char_i == CH_PLUS);
  assign cls_o.is_minus = (char_i == CH_MINUS);
  assign cls_o.is_space = (char_i == CH_SPACE);
  assign cls_o.is_alnum = (char_i >= CH_0  && char_i <= CH_9)  ||
                          (char_i >= CH_UA && char_i <= CH_UZ) ||
                          (char_i >= CH_LA && char_i <= CH_LZ);
  assign pos_o = pos;

endmodule

// File: rtl/cbnp_core.sv
// parse state, multiply-accumulate and result register
module cbnp_core import cbnp_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int IDX_W       = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  input  logic                   last_i,
  input  char_class_t            cls_i,
  input  logic [IDX_W-1:0]       pos_i,
  input  cfg_t                   cfg_i,
  input  logic                   out_ready_i,
  output logic                   fire_o,
  output logic                   out_valid_o,
  output logic [VALUE_WIDTH-1:0] value_o,
  output status_e                status_o
);

  typedef enum logic [1:0] {
    PH_SPACES  = 2'd0,
    PH_DIGITS  = 2'd1,
    PH_STOPPED = 2'd2
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic                   neg_q, neg_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic                   bad_q, bad_d;
  logic                   out_valid_q;
  logic [VALUE_WIDTH-1:0] value_q;
  status_e                status_q;

  logic                   out_free;
  logic                   fire;
  logic                   bad_char;
  logic [VALUE_WIDTH-1:0] mac;
  logic [VALUE_WIDTH-1:0] res_value;
  status_e                res_status;

  assign out_free = !out_valid_q || out_ready_i;
  // a non-last item never needs the result register
  assign fire     = item_valid_i && (!last_i || out_free);
  assign bad_char = !cls_i.hit && !cls_i.is_plus && !cls_i.is_minus && !cls_i.is_space;
  assign mac      = acc_q * VALUE_WIDTH'(cfg_i.base_len) + VALUE_WIDTH'(pos_i);

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    bad_d   = bad_q | bad_char;
    unique case (phase_q)
      PH_SPACES: begin
        if (cls_i.is_space) begin
          phase_d = PH_SPACES;
        end else if (cls_i.is_plus || cls_i.is_minus) begin
          neg_d   = cls_i.is_minus;
          phase_d = PH_DIGITS;
        end else if (cls_i.is_alnum) begin
          phase_d = PH_DIGITS;
          if (cls_i.hit) acc_d = mac;
        end else begin
          phase_d = PH_STOPPED;
        end
      end
      PH_DIGITS: begin
        if (cls_i.is_alnum) begin
          if (cls_i.hit) acc_d = mac;
        end else begin
          phase_d = PH_STOPPED;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (!cfg_i.base_ok) begin
      res_value  = '0;
      res_status = STATUS_BAD_BASE;
    end else if (bad_d) begin
      res_value  = '0;
      res_status = STATUS_BAD_CHAR;
    end else begin
      res_value  = neg_d ? (~acc_d + VALUE_WIDTH'(1)) : acc_d;
      res_status = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SPACES;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire && last_i) begin
        phase_q     <= PH_SPACES;
        neg_q       <= 1'b0;
        acc_q       <= '0;
        bad_q       <= 1'b0;
        out_valid_q <= 1'b1;
        value_q     <= res_value;
        status_q    <= res_status;
      end else begin
        if (fire) begin
          phase_q <= phase_d;
          neg_q   <= neg_d;
          acc_q   <= acc_d;
          bad_q   <= bad_d;
        end
        if (out_ready_i) out_valid_q <= 1'b0;
      end
    end
  end

  assign fire_o      = fire;
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

// File: rtl/custom_base_number_parser.sv
// a last character passes the input register, then the state and result register, where its
// result is offered until taken; one character per cycle while no last character waits, with
// the single multiply-accumulate between the two registers. characters keep flowing
// while a result waits; only a last character waits in the input register for the result.
// reset clears the configuration (base invalid until written), the parse state and valids.
module custom_base_number_parser import cbnp_pkg::*; #(
  parameter int MAX_DIGITS  = MAX_DIGITS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int OUT_DATA_W = ((VALUE_WIDTH + STATUS_W + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [CHAR_W-1:0]     s_axis_tdata,   // char_in
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // value, status, zero pad
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  cfg_t                   cfg;
  char_class_t            cls;
  logic [IDX_W-1:0]       pos;
  logic                   in_valid_q;
  logic [CHAR_W-1:0]      char_q;
  logic                   last_q;
  logic                   fire;
  logic [VALUE_WIDTH-1:0] value;
  status_e                status;

  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
        char_q     <= s_axis_tdata;
        last_q     <= s_axis_tlast;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
    end
  end

  cbnp_cfg #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cbnp_lookup #(
    .MAX_DIGITS (MAX_DIGITS),
    .IDX_W      (IDX_W)
  ) u_lookup (
    .char_i (char_q),
    .cfg_i  (cfg),
    .cls_o  (cls),
    .pos_o  (pos)
  );

  cbnp_core #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .IDX_W       (IDX_W)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_q),
    .last_i       (last_q),
    .cls_i        (cls),
    .pos_i        (pos),
    .cfg_i        (cfg),
    .out_ready_i  (m_axis_tready),
    .fire_o       (fire),
    .out_valid_o  (m_axis_tvalid),
    .value_o      (value),
    .status_o     (status)
  );

  assign m_axis_tdata = OUT_DATA_W'({status, value});

endmodule

// File: rtl/cbnp_checker.sv
// port-level checks for the custom base number parser, bound to the top level
module cbnp_checker import cbnp_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int OUT_DATA_W  = ((VALUE_WIDTH + STATUS_W + 7) / 8) * 8
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic [STATUS_W-1:0] status;
  assign status = m_axis_tdata[VALUE_WIDTH +: STATUS_W];

  // a result held back keeps its bits
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // any error reports a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status != STATUS_OK |-> m_axis_tdata[VALUE_WIDTH-1:0] == '0)
    else $error("error result with nonzero value");

  // with the output side draining, the input side never stalls
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output ready");

endmodule

bind custom_base_number_parser cbnp_checker #(
  .VALUE_WIDTH (VALUE_WIDTH),
  .OUT_DATA_W  (OUT_DATA_W)
) u_cbnp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
